// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check; reset masks the check.
`define ASSERT_AT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, expr, msg) `ASSERT_AT(lbl, !(expr), msg)

`endif

// ===== src/cbst_pkg.sv =====
package cbst_pkg;

    // Default coordinate width
    localparam int COORD_WIDTH_DEF = 16;

    // Segment count and its powers
    localparam int SEG_W = 6;
    localparam int N2_W  = 2 * SEG_W;
    localparam int N3_W  = 3 * SEG_W;
    // 6 * 63^3 fits in 21 bits
    localparam int DEN_W = N3_W + 3;

    localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(16);

    // Commands from the sequencer to the datapath, at most one per cycle
    typedef struct packed {
        logic load;
        logic scale1;
        logic scale2;
        logic scale3;
        logic horn1;
        logic horn2;
        logic horn3;
        logic div_start;
        logic div_step;
        logic emit;
    } cbst_cmd_t;

    // Status back to the sequencer
    typedef struct packed {
        logic last_pt;
    } cbst_stat_t;

endpackage

// ===== src/cbst_ifs.sv =====
// Control point channel: one beat carries the four points of a segment
interface cbst_seg_if
    import cbst_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] p1_x;
    logic signed [COORD_WIDTH-1:0] p1_y;
    logic signed [COORD_WIDTH-1:0] p2_x;
    logic signed [COORD_WIDTH-1:0] p2_y;
    logic signed [COORD_WIDTH-1:0] p3_x;
    logic signed [COORD_WIDTH-1:0] p3_y;
    logic signed [COORD_WIDTH-1:0] p4_x;
    logic signed [COORD_WIDTH-1:0] p4_y;

    modport source (
        output valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y,
        input  ready
    );

    modport sink (
        input  valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y,
        output ready
    );
endinterface

// Curve point channel: one beat per tessellated point
interface cbst_pt_if
    import cbst_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic [SEG_W-1:0]              point_index;
    logic                          last_point;
    logic signed [COORD_WIDTH-1:0] box_x_min;
    logic signed [COORD_WIDTH-1:0] box_x_max;
    logic signed [COORD_WIDTH-1:0] box_y_min;
    logic signed [COORD_WIDTH-1:0] box_y_max;

    modport source (
        output valid, point_x, point_y, point_index, last_point,
               box_x_min, box_x_max, box_y_min, box_y_max,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_index, last_point,
               box_x_min, box_x_max, box_y_min, box_y_max,
        output ready
    );
endinterface

// ===== src/cubic_bspline_segment_tessellator_core.sv =====
// Uniform cubic B-spline segment tessellator. Each beat on seg carries the four
// control points of one segment; the block answers with max(segments,1)+1 beats
// on pt, one per parameter step i = 0..N, each the curve point rounded to
// nearest (halves up), saturated to the coordinate range, and tagged with its
// index, a last-point flag and the bounding box of the control points. Each
// point takes three Horner steps, a divider load step, a restoring divider
// that retires one quotient bit per cycle, and an emit step. The next
// segment is taken once the last point sits in the output register; a
// stalled output holds the sequencer at its emit step. Write segments
// through cfg_we/cfg_wdata only while idle.
`include "assert_macros.svh"

module cubic_bspline_segment_tessellator_core
    import cbst_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [SEG_W-1:0] cfg_wdata,
    cbst_seg_if.sink         seg,
    cbst_pt_if.source        pt
);

    cbst_cmd_t  cmd;
    cbst_stat_t stat;

    // Sequencer
    cbst_ctrl #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg.valid),
        .in_ready  (seg.ready),
        .out_ready (pt.ready),
        .out_valid (pt.valid),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Arithmetic and output register
    cbst_dpath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .stat        (stat),
        .p1_x        (seg.p1_x),
        .p1_y        (seg.p1_y),
        .p2_x        (seg.p2_x),
        .p2_y        (seg.p2_y),
        .p3_x        (seg.p3_x),
        .p3_y        (seg.p3_y),
        .p4_x        (seg.p4_x),
        .p4_y        (seg.p4_y),
        .point_x     (pt.point_x),
        .point_y     (pt.point_y),
        .point_index (pt.point_index),
        .last_point  (pt.last_point),
        .box_x_min   (pt.box_x_min),
        .box_x_max   (pt.box_x_max),
        .box_y_min   (pt.box_y_min),
        .box_y_max   (pt.box_y_max)
    );

    // Sequencer and datapath consistency checks
    `ASSERT_AT(a_busy_after_accept, seg.valid && seg.ready |=> !seg.ready, "segment taken while busy")
    `ASSERT_AT(a_idle_after_last, cmd.emit && stat.last_pt |=> seg.ready, "not idle after last point")
    `ASSERT_AT(a_single_cmd, $onehot0(cmd), "more than one datapath command")
    `ASSERT_NEVER(a_emit_overwrite, cmd.emit && pt.valid && !pt.ready, "output beat overwritten")

endmodule

// ===== src/cbst_div.sv =====
// Restoring floor divider: signed numerator, positive denominator,
// one quotient bit per step, QW steps after start.
module cbst_div
    import cbst_pkg::*;
#(
    parameter int NUM_W = COORD_WIDTH_DEF + 24,
    parameter int DEN_W = cbst_pkg::DEN_W,
    parameter int QW    = COORD_WIDTH_DEF + 1
) (
    input  logic                    clk,
    input  logic                    start,
    input  logic                    step,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic signed [QW:0]      quo
);

    logic             neg_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] dsh_reg;
    logic [QW-1:0]    q_reg;
    logic [NUM_W:0]   diff;
    logic signed [QW:0] mag;
    logic signed [QW:0] rnd;

    // Trial subtract of the shifted denominator
    assign diff = {1'b0, rem_reg} - {1'b0, dsh_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            rem_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            dsh_reg <= NUM_W'(den) << (QW - 1);
            q_reg   <= '0;
        end
        else if (step)
        begin
            if (!diff[NUM_W])
            begin
                rem_reg <= diff[NUM_W-1:0];
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Round toward minus infinity for a negative numerator
    assign mag = $signed({1'b0, q_reg});
    assign rnd = $signed({{QW{1'b0}}, (rem_reg != '0)});
    assign quo = neg_reg ? -(mag + rnd) : mag;

endmodule

// ===== src/cbst_ctrl.sv =====
module cbst_ctrl
    import cbst_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_ready,
    output logic       out_valid,
    output cbst_cmd_t  cmd,
    input  cbst_stat_t stat
);

    localparam int DIV_STEPS = COORD_WIDTH + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_SCALE1   = 10'b00_0000_0010,
        ST_SCALE2   = 10'b00_0000_0100,
        ST_SCALE3   = 10'b00_0000_1000,
        ST_HORN1    = 10'b00_0001_0000,
        ST_HORN2    = 10'b00_0010_0000,
        ST_HORN3    = 10'b00_0100_0000,
        ST_DIV_LOAD = 10'b00_1000_0000,
        ST_DIV      = 10'b01_0000_0000,
        ST_EMIT     = 10'b10_0000_0000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // Sequence one segment: scale, then per point Horner, divide, emit
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCALE1;
                end
            end
            ST_SCALE1:
            begin
                cmd.scale1 = 1'b1;
                state_next = ST_SCALE2;
            end
            ST_SCALE2:
            begin
                cmd.scale2 = 1'b1;
                state_next = ST_SCALE3;
            end
            ST_SCALE3:
            begin
                cmd.scale3 = 1'b1;
                state_next = ST_HORN1;
            end
            ST_HORN1:
            begin
                cmd.horn1  = 1'b1;
                state_next = ST_HORN2;
            end
            ST_HORN2:
            begin
                cmd.horn2  = 1'b1;
                state_next = ST_HORN3;
            end
            ST_HORN3:
            begin
                cmd.horn3  = 1'b1;
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_start = 1'b1;
                cnt_next      = CNT_W'(DIV_STEPS - 1);
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.last_pt ? ST_IDLE : ST_HORN1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output beat valid: set on emit, drop when taken
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/cbst_dpath.sv =====
module cbst_dpath
    import cbst_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [SEG_W-1:0]              cfg_wdata,
    input  cbst_cmd_t                     cmd,
    output cbst_stat_t                    stat,
    input  logic signed [COORD_WIDTH-1:0] p1_x,
    input  logic signed [COORD_WIDTH-1:0] p1_y,
    input  logic signed [COORD_WIDTH-1:0] p2_x,
    input  logic signed [COORD_WIDTH-1:0] p2_y,
    input  logic signed [COORD_WIDTH-1:0] p3_x,
    input  logic signed [COORD_WIDTH-1:0] p3_y,
    input  logic signed [COORD_WIDTH-1:0] p4_x,
    input  logic signed [COORD_WIDTH-1:0] p4_y,
    output logic signed [COORD_WIDTH-1:0] point_x,
    output logic signed [COORD_WIDTH-1:0] point_y,
    output logic [SEG_W-1:0]              point_index,
    output logic                          last_point,
    output logic signed [COORD_WIDTH-1:0] box_x_min,
    output logic signed [COORD_WIDTH-1:0] box_x_max,
    output logic signed [COORD_WIDTH-1:0] box_y_min,
    output logic signed [COORD_WIDTH-1:0] box_y_max
);

    // Weight, accumulator and quotient widths
    localparam int WT_W  = COORD_WIDTH + 4;
    localparam int ACC_W = COORD_WIDTH + 24;
    localparam int QW    = COORD_WIDTH + 1;

    localparam logic signed [QW:0] Q_HI = $signed({3'b000, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [QW:0] Q_LO = $signed({3'b111, {(COORD_WIDTH-1){1'b0}}});

    logic [SEG_W-1:0] seg_reg;
    logic [SEG_W-1:0] n_reg;
    logic [N2_W-1:0]  n2_reg;
    logic [N3_W-1:0]  n3_reg;
    logic [DEN_W-1:0] den_reg;
    logic [SEG_W-1:0] i_reg;
    logic [SEG_W-1:0] point_index_reg;
    logic             last_point_reg;

    logic signed [SEG_W:0] i_s;
    logic signed [SEG_W:0] n_s;
    logic signed [N2_W:0]  n2_s;
    logic signed [N3_W:0]  n3_s;

    logic signed [COORD_WIDTH-1:0] pp [2][4];
    logic signed [COORD_WIDTH-1:0] pt_val [2];
    logic signed [COORD_WIDTH-1:0] bmin_val [2];
    logic signed [COORD_WIDTH-1:0] bmax_val [2];

    // Segment count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= SEG_RESET;
        end
        else if (cfg_we)
        begin
            seg_reg <= cfg_wdata;
        end
    end

    // Latch N, form its powers and the divisor, step the point index
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= (seg_reg == '0) ? SEG_W'(1) : seg_reg;
        end
        if (cmd.scale1)
        begin
            n2_reg <= n_reg * n_reg;
        end
        if (cmd.scale2)
        begin
            n3_reg <= n2_reg * n_reg;
        end
        if (cmd.scale3)
        begin
            den_reg <= DEN_W'({n3_reg, 2'b00}) + DEN_W'({n3_reg, 1'b0});
            i_reg   <= '0;
        end
        else if (cmd.emit)
        begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            point_index_reg <= i_reg;
            last_point_reg  <= stat.last_pt;
        end
    end

    assign stat.last_pt = (i_reg == n_reg);

    assign i_s  = $signed({1'b0, i_reg});
    assign n_s  = $signed({1'b0, n_reg});
    assign n2_s = $signed({1'b0, n2_reg});
    assign n3_s = $signed({1'b0, n3_reg});

    assign pp[0][0] = p1_x;
    assign pp[0][1] = p2_x;
    assign pp[0][2] = p3_x;
    assign pp[0][3] = p4_x;
    assign pp[1][0] = p1_y;
    assign pp[1][1] = p2_y;
    assign pp[1][2] = p3_y;
    assign pp[1][3] = p4_y;

    for (genvar ax = 0; ax < 2; ax++)
    begin : g_axis
        logic signed [WT_W-1:0] e0, e1, e2, e3;
        logic signed [WT_W-1:0] dif12, sec, dif20;
        logic signed [WT_W-1:0] a_w, b_w, c_w, d3_w;
        logic signed [WT_W-1:0] a_reg, b_reg, c_reg, d3_reg;

        logic signed [WT_W+SEG_W:0] ah_prod;
        logic signed [WT_W+SEG_W:0] bn_prod;
        logic signed [WT_W+N2_W:0]  cn2_prod;
        logic signed [WT_W+N3_W:0]  dn3_prod;
        logic signed [ACC_W+SEG_W:0] acc_prod;

        logic signed [ACC_W-1:0] bn_reg, cn2_reg, dn3_reg;
        logic signed [ACC_W-1:0] acc_reg;
        logic signed [ACC_W-1:0] acc_next;

        logic signed [COORD_WIDTH-1:0] lo01, lo23, hi01, hi23, lo_w, hi_w;
        logic signed [COORD_WIDTH-1:0] bmin_reg, bmax_reg;
        logic signed [COORD_WIDTH-1:0] obmin_reg, obmax_reg;
        logic signed [COORD_WIDTH-1:0] clamp_w, pt_reg;
        logic signed [QW:0]            quo;

        // Basis weights, with the half-step rounding bias folded into D
        assign e0    = WT_W'(pp[ax][0]);
        assign e1    = WT_W'(pp[ax][1]);
        assign e2    = WT_W'(pp[ax][2]);
        assign e3    = WT_W'(pp[ax][3]);
        assign dif12 = e1 - e2;
        assign sec   = e0 - (e1 <<< 1) + e2;
        assign dif20 = e2 - e0;
        assign a_w   = (e3 - e0) + dif12 + (dif12 <<< 1);
        assign b_w   = sec + (sec <<< 1);
        assign c_w   = dif20 + (dif20 <<< 1);
        assign d3_w  = e0 + (e1 <<< 2) + e2 + WT_W'(3);

        // Bounding box of the control points
        assign lo01 = (pp[ax][1] < pp[ax][0]) ? pp[ax][1] : pp[ax][0];
        assign lo23 = (pp[ax][3] < pp[ax][2]) ? pp[ax][3] : pp[ax][2];
        assign hi01 = (pp[ax][1] > pp[ax][0]) ? pp[ax][1] : pp[ax][0];
        assign hi23 = (pp[ax][3] > pp[ax][2]) ? pp[ax][3] : pp[ax][2];
        assign lo_w = (lo23 < lo01) ? lo23 : lo01;
        assign hi_w = (hi23 > hi01) ? hi23 : hi01;

        // Scale products, one multiply per register
        assign bn_prod  = b_reg * n_s;
        assign cn2_prod = c_reg * n2_s;
        assign dn3_prod = d3_reg * n3_s;
        assign ah_prod  = a_reg * i_s;
        assign acc_prod = acc_reg * i_s;

        // Horner over i: ((A i + B N) i + C N^2) i + (D + 3) N^3
        always_comb
        begin
            acc_next = acc_reg;
            if (cmd.horn1)
            begin
                acc_next = ACC_W'(ah_prod) + bn_reg;
            end
            else if (cmd.horn2)
            begin
                acc_next = ACC_W'(acc_prod) + cn2_reg;
            end
            else if (cmd.horn3)
            begin
                acc_next = ACC_W'(acc_prod) + dn3_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (cmd.load)
            begin
                a_reg    <= a_w;
                b_reg    <= b_w;
                c_reg    <= c_w;
                d3_reg   <= d3_w;
                bmin_reg <= lo_w;
                bmax_reg <= hi_w;
            end
            if (cmd.scale1)
            begin
                bn_reg <= ACC_W'(bn_prod);
            end
            if (cmd.scale2)
            begin
                cn2_reg <= ACC_W'(cn2_prod);
            end
            if (cmd.scale3)
            begin
                dn3_reg <= ACC_W'(dn3_prod);
            end
            acc_reg <= acc_next;
            if (cmd.emit)
            begin
                pt_reg    <= clamp_w;
                obmin_reg <= bmin_reg;
                obmax_reg <= bmax_reg;
            end
        end

        cbst_div #(
            .NUM_W (ACC_W),
            .DEN_W (DEN_W),
            .QW    (QW)
        ) u_div (
            .clk   (clk),
            .start (cmd.div_start),
            .step  (cmd.div_step),
            .num   (acc_reg),
            .den   (den_reg),
            .quo   (quo)
        );

        // Saturate to the coordinate range
        assign clamp_w = (quo > Q_HI) ? Q_HI[COORD_WIDTH-1:0] :
                         (quo < Q_LO) ? Q_LO[COORD_WIDTH-1:0] :
                                        quo[COORD_WIDTH-1:0];

        assign pt_val[ax]   = pt_reg;
        assign bmin_val[ax] = obmin_reg;
        assign bmax_val[ax] = obmax_reg;
    end

    assign point_x     = pt_val[0];
    assign point_y     = pt_val[1];
    assign point_index = point_index_reg;
    assign last_point  = last_point_reg;
    assign box_x_min   = bmin_val[0];
    assign box_x_max   = bmax_val[0];
    assign box_y_min   = bmin_val[1];
    assign box_y_max   = bmax_val[1];

endmodule
